// File: src/sha1_pkg.sv
package sha1_pkg;

  localparam int unsigned HashWords  = 5;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned RndW       = $clog2(Rounds);

  // Big-endian word: byte lane 3 is the first byte of the word in the stream.
  typedef logic [3:0][7:0]              word_t;
  typedef word_t [HashWords-1:0]        hash_t;
  typedef word_t [BlockWords-1:0]       block_t;

  localparam hash_t HashInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;
  // When bits 5:3 of the block position equal this value (56 or more bytes pending), a separate length block is needed.
  localparam logic [2:0] LenSpillHi = 3'b111;

  localparam logic [2:0] LastIdx = 3'd4;

  typedef enum logic [0:0] {
    OP_DATA   = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

endpackage

// File: src/sha1_in_if.sv
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

// File: src/sha1_out_if.sv
interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// File: src/sha1_core.sv
module sha1_core import sha1_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  hash_t  h_i,
  input  block_t blk_i,
  output logic   busy_o,
  output logic   done_o,
  output hash_t  h_o
);

  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  block_t      w_q;
  hash_t       hs_q, hout_q;
  logic [RndW-1:0] rnd_q;
  logic        busy_q, fin_q, done_q;

  logic [31:0] f, k, t, w0, wnew;

  always_comb begin
    w0 = w_q[0];
    if (rnd_q < RndW'(20)) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (rnd_q < RndW'(40)) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (rnd_q < RndW'(60)) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w0;
    wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wnew = {wnew[30:0], wnew[31]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
        done_q <= 1'b0;
      end else if (busy_q) begin
        if (rnd_q == RndW'(Rounds - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
        rnd_q  <= rnd_q + RndW'(1);
        done_q <= 1'b0;
      end else begin
        fin_q  <= 1'b0;
        done_q <= fin_q;
      end
    end
  end

  // Datapath: the message schedule is a 16-word window that shifts each round.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= h_i[0];
      b_q  <= h_i[1];
      c_q  <= h_i[2];
      d_q  <= h_i[3];
      e_q  <= h_i[4];
      hs_q <= h_i;
      w_q  <= blk_i;
    end else if (busy_q) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      for (int i = 0; i < BlockWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BlockWords-1] <= wnew;
    end else if (fin_q) begin
      hout_q[0] <= hs_q[0] + a_q;
      hout_q[1] <= hs_q[1] + b_q;
      hout_q[2] <= hs_q[2] + c_q;
      hout_q[3] <= hs_q[3] + d_q;
      hout_q[4] <= hs_q[4] + e_q;
    end
  end

  assign busy_o = busy_q | fin_q;
  assign done_o = done_q;
  assign h_o    = hout_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q && !fin_q)
    else $error("compression started while busy");

  a_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && rnd_q == RndW'(Rounds - 1) |=> !busy_q && fin_q)
    else $error("round count did not end the block");

  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(fin_q))
    else $error("done without final add");

endmodule

// File: src/sha1_byte_stream_hasher.sv
// SHA-1 hasher fed one byte per item.
//
// Input channel in_i: op = 0 appends data_byte to the message, op = 1 asks for
// the digest of the message so far. A finish leaves the message running, so
// more bytes may follow and later finishes see the longer message.
// Output channel out_o: a finish yields five items, the digest words in order,
// word_index 0 to 4, with last_word set on the fifth.
//
// Timing: an append that fills a 64-byte block starts the compression unit,
// which does one round per cycle; other appends do not hold the input, and
// after a full block the next item is taken only once its compression is
// done. A finish runs one compression, or two when 56 or more bytes of the
// current block are pending, then presents the words. The input is not
// ready while compressing or while digest words are waiting.
// If the receiver stalls, the current word holds until it is taken.
// Reset restores the initial chaining value, an empty buffer and a zero
// byte count; no item is pending after reset.
module sha1_byte_stream_hasher import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sha1_in_if.sink     in_i,
  sha1_out_if.source  out_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ABS_GO   = 7'b0000010,
    S_ABS_WAIT = 7'b0000100,
    S_FIN_GO   = 7'b0001000,
    S_FIN_WAIT = 7'b0010000,
    S_FIN_GO2  = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  hash_t       h_q, hf_q;
  block_t      buf_q;
  logic [63:0] cnt_q;
  logic        two_q;
  logic [2:0]  idx_q;

  logic [5:0]  pos;
  logic [63:0] bits;
  block_t      pad_blk, len_blk, core_blk;
  hash_t       core_h, core_hout;
  logic        core_start, core_busy, core_done;
  logic        in_acc, out_acc;

  assign pos     = cnt_q[5:0];
  assign bits    = {cnt_q[60:0], 3'b000};
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // Bytes past the current position are still zero from the last clear.
  always_comb begin
    pad_blk = buf_q;
    pad_blk[pos[5:2]][~pos[1:0]] = PadByte;
    if (pos[5:3] != LenSpillHi) begin
      pad_blk[BlockWords-2] = bits[63:32];
      pad_blk[BlockWords-1] = bits[31:0];
    end
    len_blk = '0;
    len_blk[BlockWords-2] = bits[63:32];
    len_blk[BlockWords-1] = bits[31:0];
  end

  always_comb begin
    core_start = 1'b0;
    core_h     = h_q;
    core_blk   = buf_q;
    case (state_q)
      S_ABS_GO: begin
        core_start = 1'b1;
      end
      S_FIN_GO: begin
        core_start = 1'b1;
        core_blk   = pad_blk;
      end
      S_FIN_GO2: begin
        core_start = 1'b1;
        core_h     = hf_q;
        core_blk   = len_blk;
      end
      default: begin
      end
    endcase
  end

  sha1_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .h_i     (core_h),
    .blk_i   (core_blk),
    .busy_o  (core_busy),
    .done_o  (core_done),
    .h_o     (core_hout)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.op == OP_FINISH) begin
            state_d = S_FIN_GO;
          end else if (pos == 6'h3F) begin
            state_d = S_ABS_GO;
          end
        end
      end
      S_ABS_GO:   state_d = S_ABS_WAIT;
      S_ABS_WAIT: if (core_done) state_d = S_IDLE;
      S_FIN_GO:   state_d = S_FIN_WAIT;
      S_FIN_WAIT: begin
        if (core_done) begin
          state_d = two_q ? S_FIN_GO2 : S_EMIT;
        end
      end
      S_FIN_GO2:  state_d = S_FIN_WAIT;
      S_EMIT:     if (out_acc && idx_q == LastIdx) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      h_q     <= HashInit;
      buf_q   <= '0;
      cnt_q   <= '0;
      two_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_acc && in_i.op == OP_DATA) begin
            buf_q[pos[5:2]][~pos[1:0]] <= in_i.data_byte;
            cnt_q <= cnt_q + 64'd1;
          end
        end
        S_ABS_WAIT: begin
          if (core_done) begin
            h_q   <= core_hout;
            buf_q <= '0;
          end
        end
        S_FIN_GO: begin
          two_q <= (pos[5:3] == LenSpillHi);
        end
        S_FIN_WAIT: begin
          if (core_done) begin
            two_q <= 1'b0;
            idx_q <= '0;
          end
        end
        S_EMIT: begin
          if (out_acc) idx_q <= idx_q + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN_WAIT && core_done) hf_q <= core_hout;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_EMIT);
  assign out_o.digest_word = hf_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == LastIdx);

  a_ready_core_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !core_busy)
    else $error("input ready while the compression unit runs");

  a_full_block_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.op == OP_DATA && pos == 6'h3F |=> state_q == S_ABS_GO)
    else $error("full block did not start a compression");

  a_last_word_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_o.last_word |=> in_i.ready && cnt_q == $past(cnt_q))
    else $error("block not idle after the last digest word");

endmodule
